// ===== rtl/sm4ke_pkg.sv =====
// Shared constants, types and functions for the SM4 key expansion block.
package sm4ke_pkg;

   localparam int RoundCount = 32;
   localparam int SlotWidth  = 5;

   localparam logic [31:0] Fk0 = 32'ha3b1bac6;
   localparam logic [31:0] Fk1 = 32'h56aa3350;
   localparam logic [31:0] Fk2 = 32'h677d9197;
   localparam logic [31:0] Fk3 = 32'hb27022dc;

   localparam logic ActionEncrypt = 1'b0;
   localparam logic ActionDecrypt = 1'b1;

   typedef logic [7:0] sbox_table_type [256];

   localparam sbox_table_type SboxTable = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // Byte j of CK[i] is (4*i + j) * 7 modulo 256.
   function automatic logic [31:0] ck_word(input logic [SlotWidth-1:0] round);
      logic [7:0] base;
      base = {1'b0, round, 2'b00};
      ck_word = {8'(base * 8'd7), 8'((base + 8'd1) * 8'd7),
                 8'((base + 8'd2) * 8'd7), 8'((base + 8'd3) * 8'd7)};
   endfunction

   function automatic logic [31:0] tau(input logic [31:0] v);
      tau = {SboxTable[v[31:24]], SboxTable[v[23:16]],
             SboxTable[v[15:8]], SboxTable[v[7:0]]};
   endfunction

   function automatic logic [31:0] lin_key(input logic [31:0] v);
      lin_key = v ^ {v[18:0], v[31:19]} ^ {v[8:0], v[31:9]};
   endfunction

endpackage

// ===== rtl/sm4ke_cell.sv =====
// One cell of the key word shift chain: holds one 32-bit word.
module sm4ke_cell import sm4ke_pkg::*; (
   input  logic        clock,
   input  logic        load,
   input  logic [31:0] load_word,
   input  logic        shift,
   input  logic [31:0] neighbor_word,
   output logic [31:0] word
);
   logic [31:0] word_ff, word_in;

   always_comb begin
      word_in = word_ff;
      if (load) begin
         word_in = load_word;
      end else if (shift) begin
         word_in = neighbor_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
endmodule

// ===== rtl/sm4_key_expansion.sv =====
// Top level of the SM4 key expansion block.
// An accepted key transaction loads the four cells and sets the busy flag; the round
// keys then pass through the output register, following one per cycle while rsp_stall
// does not hold it; one round unit feeding one output computes all thirty-two keys.
// A new key is accepted in the cycle the last round of the previous key is computed.
// Reset is synchronous, active high; it clears busy, the round counter and rsp_valid.
module sm4_key_expansion import sm4ke_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [63:0] req_key_high,
   input  logic [63:0] req_key_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_round_key,
   output logic [4:0]  rsp_key_slot,
   output logic        rsp_last
);
   // Four cells hold the sliding window of key words; cell 3 is the newest.
   logic [31:0] cell_word [4];
   logic [31:0] cell_load [4];

   logic             busy_ff, busy_in;
   logic [4:0]       round_ff, round_in;
   logic             action_ff, action_in;
   logic             out_valid_ff, out_valid_in;
   logic [31:0]      out_key_ff, out_key_in;
   logic [4:0]       out_slot_ff, out_slot_in;
   logic             out_last_ff, out_last_in;

   logic        out_free, step, accept, final_round;
   logic [31:0] round_key;

   // While busy, the round unit advances whenever the output register can take a word.
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign step        = busy_ff && out_free;
   assign final_round = (round_ff == 5'(RoundCount - 1));
   assign req_stall   = !(out_free && (!busy_ff || final_round));
   assign accept      = req_valid && !req_stall;

   assign cell_load[0] = req_key_high[63:32] ^ Fk0;
   assign cell_load[1] = req_key_high[31:0]  ^ Fk1;
   assign cell_load[2] = req_key_low[63:32]  ^ Fk2;
   assign cell_load[3] = req_key_low[31:0]   ^ Fk3;

   assign round_key = cell_word[0] ^
      lin_key(tau(cell_word[1] ^ cell_word[2] ^ cell_word[3] ^ ck_word(round_ff)));

   for (genvar g = 0; g < 4; g++) begin : g_cell
      sm4ke_cell u_cell (
         .clock         (clock),
         .load          (accept),
         .load_word     (cell_load[g]),
         .shift         (step),
         .neighbor_word ((g == 3) ? round_key : cell_word[(g + 1) % 4]),
         .word          (cell_word[g])
      );
   end

   always_comb begin
      busy_in      = busy_ff;
      round_in     = round_ff;
      action_in    = action_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_key_in   = out_key_ff;
      out_slot_in  = out_slot_ff;
      out_last_in  = out_last_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_key_in   = round_key;
         out_slot_in  = (action_ff == ActionDecrypt) ? ~round_ff : round_ff;
         out_last_in  = final_round;
         round_in     = round_ff + 5'd1;
         if (final_round) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in   = 1'b1;
         round_in  = '0;
         action_in = req_action;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         round_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         round_ff     <= round_in;
         out_valid_ff <= out_valid_in;
      end
      action_ff   <= action_in;
      out_key_ff  <= out_key_in;
      out_slot_ff <= out_slot_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_round_key = out_key_ff;
   assign rsp_key_slot  = out_slot_ff;
   assign rsp_last      = out_last_ff;
endmodule
